### sv/ssr_pkg.sv
// Shared types, codes and a helper function of the smoothstep speed ramp unit.
package ssr_pkg;

    // Default fraction width of the ramp position and easing values.
    localparam int FRAC_BITS_DEF = 16;

    // Field widths of the input and result beats.
    localparam int ACTION_W = 3;
    localparam int LEVEL_W = 16;
    localparam int TIME_W = 32;
    localparam int DUTY_W = 8;
    localparam int S_DATA_W = 72;
    localparam int M_DATA_W = 16;

    // Highest duty value.
    localparam logic [DUTY_W-1:0] DUTY_MAX = 8'd255;

    // Action codes of an input beat.
    localparam logic [ACTION_W-1:0] ACT_TICK = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_START = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_STOP = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_SET = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_FWD = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_BWD = 3'd5;

    // Controller states, one-hot.
    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_DIV  = 6'b000010,
        ST_SQ   = 6'b000100,
        ST_SMUL = 6'b001000,
        ST_MAG  = 6'b010000,
        ST_PUSH = 6'b100000
    } ssr_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic div_step;
        logic mul_sq;
        logic mul_s;
        logic mul_mag;
        logic push;
    } ssr_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic calc_req;
        logic div_last;
    } ssr_stat_t;

    // Clamp a signed level to the duty range.
    function automatic logic [DUTY_W-1:0] clamp_level(input logic [LEVEL_W-1:0] raw);
        logic [DUTY_W-1:0] res;
        if (raw[LEVEL_W-1]) begin
            res = '0;
        end else if (raw[LEVEL_W-2:DUTY_W] != '0) begin
            res = DUTY_MAX;
        end else begin
            res = raw[DUTY_W-1:0];
        end
        return res;
    endfunction

endpackage

### sv/ssr_ctrl.sv
// Controller state machine of the smoothstep speed ramp unit.
module ssr_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    output logic             m_tvalid,
    input  logic             m_tready,
    input  ssr_pkg::ssr_stat_t stat,
    output ssr_pkg::ssr_cmd_t  cmd
);

    ssr_pkg::ssr_state_t state_reg, state_next;
    logic m_valid_reg, m_valid_next;
    logic out_free;

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ssr_pkg::ST_IDLE);
    assign m_tvalid = m_valid_reg;

    // Sequence one item through the datapath steps.
    always_comb begin
        state_next = state_reg;
        cmd = '0;
        case (state_reg)
            ssr_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load = 1'b1;
                    state_next = stat.calc_req ? ssr_pkg::ST_DIV : ssr_pkg::ST_PUSH;
                end
            end
            ssr_pkg::ST_DIV: begin
                cmd.div_step = 1'b1;
                if (stat.div_last) begin
                    state_next = ssr_pkg::ST_SQ;
                end
            end
            ssr_pkg::ST_SQ: begin
                cmd.mul_sq = 1'b1;
                state_next = ssr_pkg::ST_SMUL;
            end
            ssr_pkg::ST_SMUL: begin
                cmd.mul_s = 1'b1;
                state_next = ssr_pkg::ST_MAG;
            end
            ssr_pkg::ST_MAG: begin
                cmd.mul_mag = 1'b1;
                state_next = ssr_pkg::ST_PUSH;
            end
            ssr_pkg::ST_PUSH: begin
                if (out_free) begin
                    cmd.push = 1'b1;
                    state_next = ssr_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ssr_pkg::ST_IDLE;
            end
        endcase
    end

    // Output beat valid flag.
    always_comb begin
        if (cmd.push) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ssr_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

### sv/ssr_dpath.sv
// Datapath of the smoothstep speed ramp unit: ramp state, divider, multipliers, output register.
module ssr_dpath #(
    parameter int FRAC_BITS = ssr_pkg::FRAC_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [ssr_pkg::S_DATA_W-1:0]  s_tdata,
    output logic [ssr_pkg::M_DATA_W-1:0]  m_tdata,
    input  ssr_pkg::ssr_cmd_t             cmd,
    output ssr_pkg::ssr_stat_t            stat
);

    localparam int F = FRAC_BITS;
    localparam int CW = $clog2(F + 1);
    localparam logic [F+1:0] THREE = {2'b11, {F{1'b0}}};
    localparam logic [F+1:0] ONE = {2'b01, {F{1'b0}}};
    localparam logic [CW-1:0] DIV_STEPS = CW'(F);

    // Input beat fields.
    logic [ssr_pkg::ACTION_W-1:0] in_action;
    logic [ssr_pkg::LEVEL_W-1:0]  in_first;
    logic [ssr_pkg::LEVEL_W-1:0]  in_final;
    logic [ssr_pkg::TIME_W-1:0]   in_time;

    assign in_action = s_tdata[2:0];
    assign in_first  = s_tdata[18:3];
    assign in_final  = s_tdata[34:19];
    assign in_time   = s_tdata[66:35];

    // Ramp state.
    logic        active_reg, active_next;
    logic [7:0]  duty_reg, duty_next;
    logic [7:0]  from_reg, from_next;
    logic [7:0]  to_reg, to_next;
    logic [31:0] len_reg, len_next;
    logic [31:0] elapsed_reg, elapsed_next;
    logic        line_a_reg, line_a_next;
    logic        line_b_reg, line_b_next;
    logic        fin_reg, fin_next;

    // Arithmetic working registers.
    logic [31:0]   rem_reg, rem_next;
    logic [F-1:0]  quo_reg, quo_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [F-1:0]  sq_reg, sq_next;
    logic [F:0]    s_reg, s_next;
    logic [ssr_pkg::M_DATA_W-1:0] out_reg, out_next;

    logic [31:0]    elapsed_inc;
    logic           ramp_end;
    logic [32:0]    rem_dbl;
    logic [32:0]    rem_sub;
    logic           rem_ge;
    logic [2*F-1:0] prod_sq;
    logic [F+1:0]   factor;
    logic [2*F+1:0] prod_s;
    logic [F+1:0]   s_raw;
    logic           up;
    logic [7:0]     abs_diff;
    logic [F+8:0]   prod_m;
    logic [8:0]     mag;
    logic [9:0]     duty_sum;
    logic [7:0]     duty_eased;

    // Saturating millisecond count and end-of-ramp test for a tick.
    assign elapsed_inc = (elapsed_reg == '1) ? elapsed_reg : elapsed_reg + 32'd1;
    assign ramp_end = (elapsed_inc >= len_reg);

    assign stat.calc_req = (in_action == ssr_pkg::ACT_TICK) && active_reg && !ramp_end;
    assign stat.div_last = (cnt_reg == CW'(1));

    // One restoring division step: one quotient bit of elapsed / length.
    assign rem_dbl = {rem_reg, 1'b0};
    assign rem_sub = rem_dbl - {1'b0, len_reg};
    assign rem_ge  = (rem_dbl >= {1'b0, len_reg});

    // Easing products, one per step.
    assign prod_sq = quo_reg * quo_reg;
    assign factor  = THREE - {1'b0, quo_reg, 1'b0};
    assign prod_s  = sq_reg * factor;
    assign s_raw   = prod_s[2*F+1:F];

    // Scaled duty offset, truncated toward zero, then clamped.
    assign up       = (to_reg >= from_reg);
    assign abs_diff = up ? (to_reg - from_reg) : (from_reg - to_reg);
    assign prod_m   = abs_diff * s_reg;
    assign mag      = prod_m[F+8:F];
    assign duty_sum = up ? ({2'b00, from_reg} + {1'b0, mag})
                         : ({2'b00, from_reg} - {1'b0, mag});
    always_comb begin
        if (duty_sum[9]) begin
            duty_eased = '0;
        end else if (duty_sum[8]) begin
            duty_eased = ssr_pkg::DUTY_MAX;
        end else begin
            duty_eased = duty_sum[7:0];
        end
    end

    // Next-state logic of all datapath registers.
    always_comb begin
        active_next  = active_reg;
        duty_next    = duty_reg;
        from_next    = from_reg;
        to_next      = to_reg;
        len_next     = len_reg;
        elapsed_next = elapsed_reg;
        line_a_next  = line_a_reg;
        line_b_next  = line_b_reg;
        fin_next     = fin_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        cnt_next     = cnt_reg;
        sq_next      = sq_reg;
        s_next       = s_reg;
        out_next     = out_reg;

        if (cmd.load) begin
            fin_next = 1'b0;
            case (in_action)
                ssr_pkg::ACT_TICK: begin
                    if (active_reg) begin
                        elapsed_next = elapsed_inc;
                        if (ramp_end) begin
                            duty_next = to_reg;
                            active_next = 1'b0;
                            fin_next = 1'b1;
                        end else begin
                            rem_next = elapsed_inc;
                            quo_next = '0;
                            cnt_next = DIV_STEPS;
                        end
                    end
                end
                ssr_pkg::ACT_START: begin
                    from_next = active_reg ? duty_reg : ssr_pkg::clamp_level(in_first);
                    to_next = ssr_pkg::clamp_level(in_final);
                    len_next = in_time;
                    elapsed_next = '0;
                    duty_next = from_next;
                    active_next = 1'b1;
                    line_a_next = 1'b1;
                    line_b_next = 1'b0;
                end
                ssr_pkg::ACT_STOP: begin
                    line_a_next = 1'b0;
                    line_b_next = 1'b0;
                    duty_next = '0;
                    active_next = 1'b0;
                end
                ssr_pkg::ACT_SET: begin
                    duty_next = ssr_pkg::clamp_level(in_first);
                end
                ssr_pkg::ACT_FWD: begin
                    line_a_next = 1'b1;
                    line_b_next = 1'b0;
                end
                ssr_pkg::ACT_BWD: begin
                    line_a_next = 1'b0;
                    line_b_next = 1'b1;
                end
                default: begin
                end
            endcase
        end

        if (cmd.div_step) begin
            rem_next = rem_ge ? rem_sub[31:0] : rem_dbl[31:0];
            quo_next = {quo_reg[F-2:0], rem_ge};
            cnt_next = cnt_reg - CW'(1);
        end

        if (cmd.mul_sq) begin
            sq_next = prod_sq[2*F-1:F];
        end

        if (cmd.mul_s) begin
            s_next = (s_raw > ONE) ? ONE[F:0] : s_raw[F:0];
        end

        if (cmd.mul_mag) begin
            duty_next = duty_eased;
        end

        if (cmd.push) begin
            out_next = {4'b0000, fin_reg, active_reg, line_b_reg, line_a_reg, duty_reg};
        end
    end

    // Ramp state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg  <= 1'b0;
            duty_reg    <= '0;
            from_reg    <= '0;
            to_reg      <= '0;
            len_reg     <= '0;
            elapsed_reg <= '0;
            line_a_reg  <= 1'b0;
            line_b_reg  <= 1'b0;
            fin_reg     <= 1'b0;
            cnt_reg     <= '0;
        end else begin
            active_reg  <= active_next;
            duty_reg    <= duty_next;
            from_reg    <= from_next;
            to_reg      <= to_next;
            len_reg     <= len_next;
            elapsed_reg <= elapsed_next;
            line_a_reg  <= line_a_next;
            line_b_reg  <= line_b_next;
            fin_reg     <= fin_next;
            cnt_reg     <= cnt_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        sq_reg  <= sq_next;
        s_reg   <= s_next;
        out_reg <= out_next;
    end

    assign m_tdata = out_reg;

endmodule

### sv/smoothstep_speed_ramp_unit.sv
// Top level of the smoothstep speed ramp unit for an H-bridge motor drive.
//
// The slave channel takes one command beat at a time: tick (one millisecond),
// start ramp, stop, set duty, forward or backward. For every accepted beat the
// master channel returns exactly one result beat with the duty, both bridge
// lines, the ramping flag and the finished flag after that command.
// A beat that needs no easing (any command other than a tick that keeps a
// running ramp going) is loaded and then pushed into the output register;
// a new beat is taken only after its result has been pushed. A tick that keeps
// a running ramp going runs a bit-serial divide for FRAC_BITS quotient bits
// and three multiply steps (square, scale, magnitude) before its result is pushed.
// Results sit in an output register; a new beat is taken while a result
// waits there. When the receiver stalls, the next result is held in the
// datapath and s_tready stays low until the output register frees up.
// Reset (aresetn low, synchronous) clears the ramp, the duty and both bridge
// lines and drops any beat that waits to be delivered.
module smoothstep_speed_ramp_unit #(
    parameter int FRAC_BITS = ssr_pkg::FRAC_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // s_tdata: action[2:0], first_level[18:3], final_level[34:19], ramp_time[66:35]
    input  logic [ssr_pkg::S_DATA_W-1:0] s_tdata,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // m_tdata: pwm_duty[7:0], bridge_a[8], bridge_b[9], ramping[10], finished[11]
    output logic [ssr_pkg::M_DATA_W-1:0] m_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready
);

    ssr_pkg::ssr_cmd_t  cmd;
    ssr_pkg::ssr_stat_t stat;

    // Controller.
    ssr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Datapath.
    ssr_dpath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tdata (s_tdata),
        .m_tdata (m_tdata),
        .cmd     (cmd),
        .stat    (stat)
    );

    // Only one item is in work at a time.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while an item is still in work");

    // A result is loaded only when the output register is free.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.push |-> (!m_tvalid || m_tready))
        else $error("result overwrote an undelivered beat");

    // A finished ramp is no longer ramping.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[11]) |-> !m_tdata[10])
        else $error("finished and ramping flags both set");

endmodule
